// ===== design/mm64_pkg.sv =====
// Shared types and constants for the MurmurHash64A block.
package mm64_pkg;

  localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [63:0] SEED_RESET = 64'd11111111;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } mm64_kind_e;

  typedef struct packed {
    logic [63:0] word;
    logic [31:0] len;
    mm64_kind_e  kind;
    logic        first;
    logic        last;
  } mm64_item_t;

endpackage

// ===== design/murmur64a_hash.sv =====
// Top level of the MurmurHash64A message hasher.
// Words enter a two-entry queue at once and are hashed one at a time by a
// sequencer built around one shared 32x32 multiplier; every 64-bit multiply by
// the mix constant takes three partial products. A full 8-byte word needs
// three multiplies, a 1..7 byte tail one and an empty word none; the first
// word of a message adds one multiply for the length seed and the last word
// adds one multiply for finalization plus a hand-off through the ST_HOLD
// state to the output register. The seed is to be written through the cfg
// port while no message is in flight; the block itself does not enforce
// this. The seed resets to 11111111. Only the low LENGTH_WIDTH bits of the
// length (at most 32) are used.
module murmur64a_hash #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);
  import mm64_pkg::*;

  logic        push, full, pop, q_valid;
  mm64_item_t  f_item, q_item;
  logic [63:0] seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_valid_i) begin
      seed_q <= hash_seed_i;
    end
  end

  mm64_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_word_i     (data_word_i),
    .valid_bytes_i   (valid_bytes_i),
    .last_word_i     (last_word_i),
    .message_length_i(message_length_i),
    .push_o          (push),
    .item_o          (f_item),
    .full_i          (full)
  );

  mm64_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  mm64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (pop),
    .q_item_i    (q_item),
    .seed_i      (seed_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_value_o(hash_value_o)
  );

endmodule

// ===== design/mm64_front.sv =====
// Front end: accepts input words, masks tails, tags message start and kind.
module mm64_front #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        data_word_i,
  input  logic [3:0]         valid_bytes_i,
  input  logic               last_word_i,
  input  logic [31:0]        message_length_i,
  output logic               push_o,
  output mm64_pkg::mm64_item_t item_o,
  input  logic               full_i
);
  import mm64_pkg::*;

  localparam logic [31:0] LenMask =
    (LENGTH_WIDTH >= 32) ? 32'hffff_ffff : 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

  logic       in_message_q, in_message_d;
  logic [3:0] cnt;
  logic [63:0] keep;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // counts 8..15 all mean a full word
  assign cnt = valid_bytes_i[3] ? 4'd8 : valid_bytes_i;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      keep[b*8 +: 8] = (4'(b) < cnt) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    item_o.word  = data_word_i & keep;
    item_o.len   = message_length_i & LenMask;
    item_o.first = !in_message_q;
    item_o.last  = last_word_i;
    if (cnt == 4'd8) begin
      item_o.kind = KIND_FULL;
    end else if (cnt != 4'd0) begin
      item_o.kind = KIND_TAIL;
    end else begin
      item_o.kind = KIND_NONE;
    end
  end

  assign in_message_d = push_o ? !last_word_i : in_message_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q <= 1'b0;
    end else begin
      in_message_q <= in_message_d;
    end
  end

endmodule

// ===== design/mm64_queue.sv =====
// Two-entry queue of classified words between front and back.
module mm64_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mm64_pkg::mm64_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output mm64_pkg::mm64_item_t item_o
);
  import mm64_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mm64_item_t         mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/mm64_mul.sv =====
// Iterative 64-bit multiply by the mix constant, low half, on one 32x32 multiplier.
module mm64_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import mm64_pkg::*;

  typedef enum logic [1:0] {
    STEP_LL,
    STEP_HL,
    STEP_LH
  } step_e;

  step_e       step_q;
  logic        busy_q, done_q;
  logic [63:0] a_q, acc_q, acc_d;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  always_comb begin
    unique case (step_q)
      STEP_LL: begin
        op_x = a_q[31:0];
        op_y = MIX_MUL[31:0];
      end
      STEP_HL: begin
        op_x = a_q[63:32];
        op_y = MIX_MUL[31:0];
      end
      STEP_LH: begin
        op_x = a_q[31:0];
        op_y = MIX_MUL[63:32];
      end
      default: begin
        op_x = a_q[31:0];
        op_y = MIX_MUL[31:0];
      end
    endcase
  end

  assign prod = 64'(op_x) * 64'(op_y);

  always_comb begin
    if (step_q == STEP_LL) begin
      acc_d = prod;
    end else begin
      acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LL;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_LL;
    end else if (busy_q) begin
      unique case (step_q)
        STEP_LL: begin
          step_q <= STEP_HL;
          done_q <= 1'b0;
        end
        STEP_HL: begin
          step_q <= STEP_LH;
          done_q <= 1'b0;
        end
        STEP_LH: begin
          step_q <= STEP_LL;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        default: begin
          step_q <= STEP_LL;
          busy_q <= 1'b0;
          done_q <= 1'b0;
        end
      endcase
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/mm64_back.sv =====
// Back end: sequences seeding, word mixing and finalization over the multiplier.
module mm64_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  mm64_pkg::mm64_item_t q_item_i,
  input  logic [63:0]          seed_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          hash_value_o
);
  import mm64_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_KEY1,
    ST_KEY2,
    ST_HASH,
    ST_FIN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    state_e      st;
    logic        start;
    logic [63:0] a;
  } launch_t;

  state_e      state_q, state_d;
  mm64_item_t  item_q, item_d;
  logic [63:0] h_q, h_d, mul_a_q, mul_a_d, out_q, out_d;
  logic        mul_start_q, mul_start_d, out_valid_q, out_valid_d;
  logic        mul_done;
  logic [63:0] mul_p;
  launch_t     ln;

  function automatic launch_t after_mix(mm64_item_t it, logic [63:0] h);
    launch_t r;
    if (it.last) begin
      r.st    = ST_FIN;
      r.start = 1'b1;
      r.a     = h ^ (h >> MIX_SHIFT);
    end else begin
      r.st    = ST_IDLE;
      r.start = 1'b0;
      r.a     = h;
    end
    return r;
  endfunction

  function automatic launch_t after_seed(mm64_item_t it, logic [63:0] h);
    launch_t r;
    unique case (it.kind)
      KIND_FULL: begin
        r.st    = ST_KEY1;
        r.start = 1'b1;
        r.a     = it.word;
      end
      KIND_TAIL: begin
        r.st    = ST_HASH;
        r.start = 1'b1;
        r.a     = h ^ it.word;
      end
      default: r = after_mix(it, h);
    endcase
    return r;
  endfunction

  mm64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .a_i    (mul_a_q),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign q_pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    h_d         = h_q;
    mul_start_d = 1'b0;
    mul_a_d     = mul_a_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ln          = '{st: ST_IDLE, start: 1'b0, a: '0};
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          item_d = q_item_i;
          if (q_item_i.first) begin
            ln = '{st: ST_SEED, start: 1'b1, a: 64'(q_item_i.len)};
          end else begin
            ln = after_seed(q_item_i, h_q);
          end
          state_d     = ln.st;
          mul_start_d = ln.start;
          mul_a_d     = ln.a;
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          h_d         = seed_i ^ mul_p;
          ln          = after_seed(item_q, seed_i ^ mul_p);
          state_d     = ln.st;
          mul_start_d = ln.start;
          mul_a_d     = ln.a;
        end
      end
      ST_KEY1: begin
        if (mul_done) begin
          state_d     = ST_KEY2;
          mul_start_d = 1'b1;
          mul_a_d     = mul_p ^ (mul_p >> MIX_SHIFT);
        end
      end
      ST_KEY2: begin
        if (mul_done) begin
          state_d     = ST_HASH;
          mul_start_d = 1'b1;
          mul_a_d     = h_q ^ mul_p;
        end
      end
      ST_HASH: begin
        if (mul_done) begin
          h_d         = mul_p;
          ln          = after_mix(item_q, mul_p);
          state_d     = ln.st;
          mul_start_d = ln.start;
          mul_a_d     = ln.a;
        end
      end
      ST_FIN: begin
        if (mul_done) begin
          h_d     = mul_p ^ (mul_p >> MIX_SHIFT);
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = h_q;
          out_valid_d = 1'b1;
          h_d         = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= '0;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      mul_a_q     <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      mul_start_q <= mul_start_d;
      out_valid_q <= out_valid_d;
      item_q      <= item_d;
      mul_a_q     <= mul_a_d;
      out_q       <= out_d;
    end
  end

endmodule

// ===== design/mm64_checker.sv =====
// Port-level checks for the MurmurHash64A hasher, bound to the top level.
module mm64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_value_o
);

  logic [2:0] pending_q;
  logic       last_in, word_out;

  assign last_in  = in_valid_i && in_ready_o && last_word_i;
  assign word_out = out_valid_o && out_ready_i;

  // messages closed at the input whose hash has not yet been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (last_in && !word_out) begin
      pending_q <= pending_q + 3'd1;
    end else if (word_out && !last_in) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("output word dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("hash presented without a closed message");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more closed messages in flight than the design can hold");

endmodule

bind murmur64a_hash mm64_checker u_checker (.*);
